>>> rtl/lsa_pkg.sv
`timescale 1ns / 1ps

package lsa_pkg;

	localparam int KEY_W     = 64;
	localparam int IDX_W     = 9;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 1;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_EVICT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REUSE_UNIQUE = 1'd1;

	typedef struct packed {
		logic                clear;
		logic                capture;
		logic                rd_links;
		logic                rd_key;
		logic                wr_key_new;
		logic                wr_key_zero;
		logic                wr_self;
		logic                wr_unlink;
		logic                wr_splice;
		logic                upd_move;
		logic                upd_evict;
		logic                load_res;
		logic [STATUS_W-1:0] res_status;
		logic                res_grant;
		logic                res_evicted;
	} lsa_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_release;
		logic idx_ok;
		logic key_match;
		logic free_avail;
		logic lru_avail;
		logic manual_evict;
		logic unlink_needed;
		logic dst_nonempty;
		logic out_free;
	} lsa_sts_t;

endpackage

>>> rtl/lsa_ctrl.sv
`timescale 1ns / 1ps

module lsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lsa_pkg::lsa_sts_t sts,
	output lsa_pkg::lsa_cmd_t cmd
);
	import lsa_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_CHECK,
		S_SELF,
		S_UNLINK,
		S_SPLICE,
		S_EVICT,
		S_RSP
	} state_t;

	state_t              state_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_grant_q;
	logic                res_evicted_q;
	logic                accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd             = '0;
		cmd.res_status  = res_status_q;
		cmd.res_grant   = res_grant_q;
		cmd.res_evicted = res_evicted_q;
		case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: cmd.capture = accept;
			S_LOOK: begin
				if (sts.is_release) begin
					if (sts.idx_ok) begin
						cmd.rd_key   = 1'b1;
						cmd.rd_links = 1'b1;
					end
				end else if (sts.free_avail) begin
					cmd.rd_links   = 1'b1;
					cmd.wr_key_new = 1'b1;
				end else if (!sts.manual_evict && sts.lru_avail) begin
					cmd.rd_links = 1'b1;
					cmd.rd_key   = 1'b1;
				end
			end
			S_CHECK: begin
				if (sts.key_match) begin
					cmd.wr_key_zero = 1'b1;
					cmd.wr_self     = 1'b1;
				end
			end
			S_SELF: cmd.wr_self = 1'b1;
			S_UNLINK: cmd.wr_unlink = sts.unlink_needed;
			S_SPLICE: begin
				cmd.wr_splice = sts.dst_nonempty;
				cmd.upd_move  = 1'b1;
			end
			S_EVICT: begin
				cmd.upd_evict  = 1'b1;
				cmd.wr_key_new = 1'b1;
			end
			S_RSP: cmd.load_res = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			res_status_q  <= ST_DONE;
			res_grant_q   <= 1'b0;
			res_evicted_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (accept) state_q <= S_LOOK;
				S_LOOK: begin
					if (sts.is_release) begin
						res_grant_q   <= 1'b0;
						res_evicted_q <= 1'b0;
						if (sts.idx_ok) begin
							state_q <= S_CHECK;
						end else begin
							res_status_q <= ST_IGNORED;
							state_q      <= S_RSP;
						end
					end else if (sts.free_avail) begin
						res_status_q  <= ST_DONE;
						res_grant_q   <= 1'b1;
						res_evicted_q <= 1'b0;
						state_q       <= S_SELF;
					end else if (sts.manual_evict || !sts.lru_avail) begin
						res_status_q  <= ST_BUSY;
						res_grant_q   <= 1'b0;
						res_evicted_q <= 1'b0;
						state_q       <= S_RSP;
					end else begin
						res_status_q  <= ST_DONE;
						res_grant_q   <= 1'b1;
						res_evicted_q <= 1'b1;
						state_q       <= S_EVICT;
					end
				end
				S_CHECK: begin
					if (sts.key_match) begin
						res_status_q <= ST_DONE;
						state_q      <= S_UNLINK;
					end else begin
						res_status_q <= ST_IGNORED;
						state_q      <= S_RSP;
					end
				end
				S_SELF: state_q <= S_UNLINK;
				S_UNLINK: state_q <= S_SPLICE;
				S_SPLICE: state_q <= S_RSP;
				S_EVICT: state_q <= S_RSP;
				S_RSP: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/lsa_datapath.sv
`timescale 1ns / 1ps

module lsa_datapath #(
	parameter int SLOTS = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           opcode,
	input  logic [lsa_pkg::KEY_W-1:0]      slot_key,
	input  logic [lsa_pkg::IDX_W-1:0]      slot_index,
	input  lsa_pkg::lsa_cmd_t              cmd,
	output lsa_pkg::lsa_sts_t              sts,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [lsa_pkg::STATUS_W-1:0]   status,
	output logic [lsa_pkg::IDX_W-1:0]      granted_index,
	output logic                           evicted,
	output logic [lsa_pkg::KEY_W-1:0]      evicted_key
);
	import lsa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int XW = (IW > IDX_W) ? IW : IDX_W;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	logic manual_q, reuse_q;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic [IW-1:0]    s_q;
	logic [XW-1:0]    idx_x;
	logic [XW-1:0]    s_x;
	logic [IW-1:0]    s_sel;

	logic          free_v_q, lru_v_q;
	logic [IW-1:0] free_h_q, free_t_q, lru_h_q, lru_t_q;
	logic          dst_v;
	logic [IW-1:0] dst_h, dst_t;
	logic [IW-1:0] clr_cnt_q;

	logic [KEY_W-1:0] key_mem  [SLOTS];
	logic [IW-1:0]    next_mem [SLOTS];
	logic [IW-1:0]    prev_mem [SLOTS];
	logic [KEY_W-1:0] key_rd_q;
	logic [IW-1:0]    next_rd_q, prev_rd_q;
	logic [KEY_W-1:0] old_key_q;

	logic             key_we, next_we, prev_we;
	logic [IW-1:0]    key_addr, next_addr, prev_addr;
	logic [KEY_W-1:0] key_wd;
	logic [IW-1:0]    next_wd, prev_wd;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    granted_q;
	logic                evicted_q;
	logic [KEY_W-1:0]    evicted_key_q;
	logic                unlink_needed;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q <= 1'b0;
			reuse_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MANUAL_EVICT: manual_q <= cfg_data[0];
				REG_REUSE_UNIQUE: reuse_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item capture; target slot chosen up front
	assign idx_x = XW'(slot_index);
	assign s_sel = (opcode == OP_RELEASE) ? idx_x[IW-1:0] : (free_v_q ? free_h_q : lru_h_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			key_q <= slot_key;
			idx_q <= slot_index;
			s_q   <= s_sel;
		end
	end

	// allocate inserts into the LRU ring, release into the free ring
	assign dst_v = (op_q == OP_RELEASE) ? free_v_q : lru_v_q;
	assign dst_h = (op_q == OP_RELEASE) ? free_h_q : lru_h_q;
	assign dst_t = (op_q == OP_RELEASE) ? free_t_q : lru_t_q;

	assign unlink_needed = (next_rd_q != s_q);

	always_comb begin
		next_addr = s_q;
		next_wd   = s_q;
		next_we   = 1'b0;
		prev_addr = s_q;
		prev_wd   = s_q;
		prev_we   = 1'b0;
		key_addr  = s_q;
		key_wd    = key_q;
		key_we    = 1'b0;
		if (cmd.clear) begin
			next_addr = clr_cnt_q;
			next_wd   = (clr_cnt_q == LAST) ? '0 : clr_cnt_q + 1'b1;
			next_we   = 1'b1;
			prev_addr = clr_cnt_q;
			prev_wd   = (clr_cnt_q == '0) ? LAST : clr_cnt_q - 1'b1;
			prev_we   = 1'b1;
			key_addr  = clr_cnt_q;
			key_wd    = '0;
			key_we    = 1'b1;
		end
		if (cmd.wr_self) begin
			next_wd = dst_v ? dst_h : s_q;
			next_we = 1'b1;
			prev_wd = dst_v ? dst_t : s_q;
			prev_we = 1'b1;
		end
		if (cmd.wr_unlink) begin
			next_addr = prev_rd_q;
			next_wd   = next_rd_q;
			next_we   = 1'b1;
			prev_addr = next_rd_q;
			prev_wd   = prev_rd_q;
			prev_we   = 1'b1;
		end
		if (cmd.wr_splice) begin
			next_addr = dst_t;
			next_wd   = s_q;
			next_we   = 1'b1;
			prev_addr = dst_h;
			prev_wd   = s_q;
			prev_we   = 1'b1;
		end
		if (cmd.wr_key_new) begin
			key_we = 1'b1;
		end
		if (cmd.wr_key_zero) begin
			key_wd = '0;
			key_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_addr] <= key_wd;
		if (cmd.rd_key) key_rd_q <= key_mem[key_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_addr] <= next_wd;
		if (cmd.rd_links) next_rd_q <= next_mem[next_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_addr] <= prev_wd;
		if (cmd.rd_links) prev_rd_q <= prev_mem[prev_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// ring heads and tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_v_q <= 1'b1;
			free_h_q <= '0;
			free_t_q <= LAST;
			lru_v_q  <= 1'b0;
			lru_h_q  <= '0;
			lru_t_q  <= '0;
		end else if (cmd.upd_evict) begin
			lru_h_q <= next_rd_q;
			lru_t_q <= s_q;
		end else if (cmd.upd_move) begin
			if (op_q == OP_RELEASE) begin
				if (!unlink_needed) begin
					lru_v_q <= 1'b0;
				end else begin
					if (lru_h_q == s_q) lru_h_q <= next_rd_q;
					if (lru_t_q == s_q) lru_t_q <= prev_rd_q;
				end
				if (!free_v_q) begin
					free_v_q <= 1'b1;
					free_h_q <= s_q;
					free_t_q <= s_q;
				end else if (reuse_q) begin
					free_t_q <= s_q;
				end else begin
					free_h_q <= s_q;
				end
			end else begin
				if (!unlink_needed) begin
					free_v_q <= 1'b0;
				end else begin
					if (free_h_q == s_q) free_h_q <= next_rd_q;
					if (free_t_q == s_q) free_t_q <= prev_rd_q;
				end
				if (!lru_v_q) begin
					lru_v_q <= 1'b1;
					lru_h_q <= s_q;
					lru_t_q <= s_q;
				end else begin
					lru_t_q <= s_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_evict) old_key_q <= key_rd_q;
	end

	assign sts.clr_done      = (clr_cnt_q == LAST);
	assign sts.is_release    = (op_q == OP_RELEASE);
	assign sts.idx_ok        = (32'(idx_q) < 32'(SLOTS));
	assign sts.key_match     = (key_rd_q == key_q) && (key_q != '0);
	assign sts.free_avail    = free_v_q;
	assign sts.lru_avail     = lru_v_q;
	assign sts.manual_evict  = manual_q;
	assign sts.unlink_needed = unlink_needed;
	assign sts.dst_nonempty  = dst_v;
	assign sts.out_free      = !out_valid_q || !out_stall;

	// output register
	assign s_x = XW'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			status_q      <= cmd.res_status;
			granted_q     <= cmd.res_grant ? s_x[IDX_W-1:0] : '0;
			evicted_q     <= cmd.res_evicted;
			evicted_key_q <= cmd.res_evicted ? old_key_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign evicted       = evicted_q;
	assign evicted_key   = evicted_key_q;

`ifndef SYNTH
	a_ring_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		free_v_q || lru_v_q)
		else $error("both rings empty");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a waiting item");

	a_splice_dst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_splice |-> dst_v)
		else $error("splice into an empty ring");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_self || cmd.wr_unlink || cmd.wr_splice) |-> !cmd.clear)
		else $error("link write during clearing pass");

	a_evict_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && evicted_q) |-> (status_q == ST_DONE))
		else $error("eviction result inconsistent");
`endif

endmodule

>>> rtl/lru_slot_allocator.sv
`timescale 1ns / 1ps

// Slot allocator with a free ring and an LRU ring held in single-port link memories.
// After reset a clearing pass initialises keys and links; items are
// held off until it ends, configuration writes are taken throughout. After the
// lookup, a free-slot allocate runs self, unlink and splice, a matching release
// check, unlink and splice, an eviction the evict step and a key mismatch check;
// busy or out-of-range results respond directly. The link memories take one access
// per cycle. A result waits in an output register; the next item is still taken,
// and waits in its last cycle while that register is full.

module lru_slot_allocator #(
	parameter int SLOTS = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsa_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [lsa_pkg::KEY_W-1:0]      slot_key,
	input  logic [lsa_pkg::IDX_W-1:0]      slot_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lsa_pkg::STATUS_W-1:0]   status,
	output logic [lsa_pkg::IDX_W-1:0]      granted_index,
	output logic                           evicted,
	output logic [lsa_pkg::KEY_W-1:0]      evicted_key
);
	import lsa_pkg::*;

	lsa_cmd_t cmd;
	lsa_sts_t sts;

	lsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsa_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.slot_key      (slot_key),
		.slot_index    (slot_index),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.granted_index (granted_index),
		.evicted       (evicted),
		.evicted_key   (evicted_key)
	);

endmodule

>>> tb/lru_slot_allocator_tb.sv
`timescale 1ns / 1ps

module lru_slot_allocator_tb;

	import lsa_pkg::*;

	localparam int SLOTS = 512;
	localparam logic [IDX_W:0] NO_SLOT = (IDX_W + 1)'(SLOTS);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    granted;
		logic                evicted;
		logic [KEY_W-1:0]    old_key;
	} slot_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [KEY_W-1:0]     slot_key;
	logic [IDX_W-1:0]     slot_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [IDX_W-1:0]     granted_index;
	logic                 evicted;
	logic [KEY_W-1:0]     evicted_key;

	// mirror of the slot table and both rings
	logic [KEY_W-1:0] key_mirror [SLOTS];
	logic [IDX_W-1:0] next_of [SLOTS];
	logic [IDX_W-1:0] prev_of [SLOTS];
	logic [IDX_W:0]   lru_head;
	logic [IDX_W:0]   free_head;
	logic             manual_mode;
	logic             unique_reuse;
	int               free_slots;

	slot_result_t pending_results [$];
	int           errors;
	bit           tx_idle;
	bit           rx_idle;
	int           rx_hold;
	int           rx_burst;

	lru_slot_allocator #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.slot_key(slot_key),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_index(granted_index),
		.evicted(evicted),
		.evicted_key(evicted_key)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		rand_key = {$urandom, $urandom};
	endfunction

	function automatic void clear_mirror();
		for (int i = 0; i < SLOTS; i++) begin
			key_mirror[i] = '0;
			next_of[i] = IDX_W'((i + 1) % SLOTS);
			prev_of[i] = IDX_W'((i + SLOTS - 1) % SLOTS);
		end
		lru_head = NO_SLOT;
		free_head = '0;
		manual_mode = 1'b0;
		unique_reuse = 1'b0;
		free_slots = SLOTS;
	endfunction

	task automatic ring_unlink(inout logic [IDX_W:0] head, input logic [IDX_W-1:0] s);
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] p;
		n = next_of[s];
		p = prev_of[s];
		if (n == s) begin
			head = NO_SLOT;
		end else begin
			prev_of[n] = p;
			next_of[p] = n;
			if (head == {1'b0, s})
				head = {1'b0, n};
		end
	endtask

	task automatic ring_link(inout logic [IDX_W:0] head, input logic [IDX_W-1:0] s,
		input logic at_tail);
		logic [IDX_W-1:0] h;
		logic [IDX_W-1:0] t;
		if (head == NO_SLOT) begin
			next_of[s] = s;
			prev_of[s] = s;
			head = {1'b0, s};
		end else begin
			h = head[IDX_W-1:0];
			t = prev_of[h];
			next_of[s] = h;
			prev_of[s] = t;
			next_of[t] = s;
			prev_of[h] = s;
			if (!at_tail)
				head = {1'b0, s};
		end
	endtask

	task automatic predict_slot_op(input logic op, input logic [KEY_W-1:0] key,
		input logic [IDX_W-1:0] idx);
		slot_result_t r;
		logic [IDX_W-1:0] s;
		r = '0;
		if (op == OP_ALLOC) begin
			if (free_head != NO_SLOT) begin
				s = free_head[IDX_W-1:0];
				ring_unlink(free_head, s);
				ring_link(lru_head, s, 1'b1);
				key_mirror[s] = key;
				r.granted = s;
				free_slots--;
			end else if (manual_mode || lru_head == NO_SLOT) begin
				r.status = ST_BUSY;
			end else begin
				// reuse the coldest slot
				s = lru_head[IDX_W-1:0];
				r.old_key = key_mirror[s];
				key_mirror[s] = key;
				lru_head = {1'b0, next_of[s]};
				r.granted = s;
				r.evicted = 1'b1;
			end
		end else if (key == '0 || key_mirror[idx] != key) begin
			r.status = ST_IGNORED;
		end else begin
			key_mirror[idx] = '0;
			ring_unlink(lru_head, idx);
			ring_link(free_head, idx, unique_reuse);
			free_slots++;
		end
		pending_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] want,
		input logic [KEY_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// receiver: stall bursts, long hold-offs, result checks
	initial begin
		slot_result_t want;
		out_stall = 1'b0;
		rx_burst = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, status %0d index %0d", $time,
						status, granted_index);
				end else begin
					want = pending_results.pop_front();
					check_field("status", KEY_W'(want.status), KEY_W'(status));
					check_field("granted_index", KEY_W'(want.granted),
						KEY_W'(granted_index));
					check_field("evicted", KEY_W'(want.evicted), KEY_W'(evicted));
					check_field("evicted_key", want.old_key, evicted_key);
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_burst > 0) begin
				rx_burst--;
				out_stall <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				rx_burst = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
		input logic [IDX_W-1:0] idx);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		slot_key <= key;
		slot_index <= idx;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_slot_op(op, key, idx);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0 || in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_config(input logic manual, input logic unique_tail);
		in_valid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_MANUAL_EVICT;
		cfg_data <= manual;
		@(posedge clk);
		cfg_index <= REG_REUSE_UNIQUE;
		cfg_data <= unique_tail;
		@(posedge clk);
		cfg_we <= 1'b0;
		manual_mode = manual;
		unique_reuse = unique_tail;
	endtask

	// allocations and mostly well-formed releases of live slots, plus some noise
	task automatic random_item();
		int pick;
		int start;
		logic [IDX_W-1:0] s;
		bit found;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		found = 0;
		s = '0;
		if (pick >= 48) begin
			start = $urandom_range(0, SLOTS - 1);
			for (int i = 0; i < SLOTS && !found; i++) begin
				s = IDX_W'((start + i) % SLOTS);
				if (key_mirror[s] != '0)
					found = 1;
			end
		end
		k = rand_key();
		if (pick < 48 || !found)
			send_item(OP_ALLOC, (pick < 2) ? '0 : k, IDX_W'($urandom));
		else if (pick < 88)
			send_item(OP_RELEASE, key_mirror[s], s);
		else if (pick < 93)
			send_item(OP_RELEASE, key_mirror[s] ^ (64'd1 << $urandom_range(0, 63)), s);
		else if (pick < 96)
			send_item(OP_RELEASE, k, IDX_W'($urandom));
		else
			send_item(OP_RELEASE, '0, s);
	endtask

	task automatic test_directed();
		tx_idle = 1;
		rx_idle = 1;
		write_config(1'b0, 1'b0);
		send_item(OP_ALLOC, '1, '0);
		send_item(OP_ALLOC, 64'd1, '1);
		send_item(OP_ALLOC, '0, '0);
		send_item(OP_ALLOC, 64'h8000_0000_0000_0000, 9'h155);
		send_item(OP_RELEASE, 64'd1, 9'd1);
		send_item(OP_ALLOC, 64'hA5A5_5A5A_0F0F_F0F0, 9'h0AA);
		// zero key never releases, even against a zero slot
		send_item(OP_RELEASE, '0, 9'd2);
		send_item(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFE, 9'd0);
		send_item(OP_RELEASE, 64'd5, '1);
		send_item(OP_RELEASE, '1, 9'd0);
		send_item(OP_RELEASE, '1, 9'd0);
		send_item(OP_ALLOC, 64'h0123_4567_89AB_CDEF, '1);
		write_config(1'b0, 1'b1);
		send_item(OP_RELEASE, 64'h8000_0000_0000_0000, 9'd3);
		send_item(OP_RELEASE, 64'hA5A5_5A5A_0F0F_F0F0, 9'd1);
		send_item(OP_ALLOC, 64'hDEAD_BEEF_0000_0001, '0);
		send_item(OP_ALLOC, 64'h7FFF_FFFF_FFFF_FFFF, '0);
	endtask

	task automatic test_fill_and_evict();
		write_config(1'b0, 1'b0);
		while (free_slots > 0)
			send_item(OP_ALLOC, rand_key(), IDX_W'($urandom));
		repeat (40) send_item(OP_ALLOC, rand_key(), IDX_W'($urandom));
	endtask

	task automatic test_manual_busy();
		int s;
		write_config(1'b1, 1'b0);
		repeat (6) send_item(OP_ALLOC, rand_key(), IDX_W'($urandom));
		s = $urandom_range(0, SLOTS - 1);
		repeat (8) begin
			while (key_mirror[s] == '0)
				s = (s + 1) % SLOTS;
			send_item(OP_RELEASE, key_mirror[s], IDX_W'(s));
		end
		repeat (10) send_item(OP_ALLOC, rand_key(), IDX_W'($urandom));
	endtask

	task automatic test_random_mix();
		for (int ph = 0; ph < 4; ph++) begin
			write_config(ph[0] ^ ph[1], !ph[1]);
			for (int n = 0; n < 130; n++) begin
				if (n % 40 == 0) begin
					tx_idle = $urandom_range(0, 3) != 0;
					rx_idle = $urandom_range(0, 3) != 0;
				end
				random_item();
			end
		end
	endtask

	task automatic test_backpressure();
		tx_idle = 0;
		rx_hold = 400;
		repeat (40) random_item();
		tx_idle = 1;
		rx_idle = 1;
	endtask

	task automatic test_no_idle();
		tx_idle = 0;
		rx_idle = 0;
		write_config(1'b0, 1'b1);
		repeat (150) random_item();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		slot_key = '0;
		slot_index = '0;
		errors = 0;
		rx_hold = 0;
		tx_idle = 0;
		rx_idle = 0;
		clear_mirror();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_evict();
		test_manual_busy();
		test_random_mix();
		test_backpressure();
		test_no_idle();
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
